// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the carver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define GUFWC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define GUFWC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/gufwc_pkg.sv =====
// ----------------------------------------------------------------------------
// gufwc_pkg
// Types, constants and helpers shared by the maze carver modules.
// ----------------------------------------------------------------------------
package gufwc_pkg;

    localparam int CELLS  = 256;
    localparam int ADDR_W = 8;
    localparam int SIZE_W = 9;
    localparam int WALL_W = 4;
    localparam int GW_W   = 5;
    localparam int CNT_W  = 9;

    localparam logic [SIZE_W-1:0] SIZE_CAP    = 9'h1FF;
    localparam logic [GW_W-1:0]   GW_RESET    = 5'd16;
    localparam logic [CNT_W-1:0]  CNT_RESET   = 9'd256;
    localparam logic [CNT_W-1:0]  CNT_MAX     = 9'd256;

    // Configuration register indexes.
    localparam logic REG_GRID_WIDTH = 1'b0;
    localparam logic REG_CELL_COUNT = 1'b1;

    // Carve directions.
    localparam logic [1:0] DIR_TOP    = 2'd0;
    localparam logic [1:0] DIR_BOTTOM = 2'd1;
    localparam logic [1:0] DIR_LEFT   = 2'd2;
    localparam logic [1:0] DIR_RIGHT  = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] cell_req;
        logic [1:0]        direction;
    } req_t;

    typedef struct packed {
        logic              neighbour_valid;
        logic              joined;
        logic [ADDR_W-1:0] neighbour;
        logic [ADDR_W-1:0] set_root;
        logic [WALL_W-1:0] cell_walls;
    } rsp_t;

    // One table entry: union-find parent, set size and the four walls.
    typedef struct packed {
        logic [ADDR_W-1:0] parent;
        logic [SIZE_W-1:0] size;
        logic [WALL_W-1:0] walls;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_FR,
        S_FU,
        S_CR,
        S_CU,
        S_UAR,
        S_UAU,
        S_UBR,
        S_UBU,
        S_UAW,
        S_WCR,
        S_WCU,
        S_WNR,
        S_WNU,
        S_WFR,
        S_WFU,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        CALL_CELL,
        CALL_NB,
        CALL_FINAL
    } call_t;

    // Value of an entry that has never been written.
    function automatic entry_t reset_entry(logic [ADDR_W-1:0] idx);
        entry_t e;
        e.parent = idx;
        e.size   = SIZE_W'(1);
        e.walls  = '1;
        return e;
    endfunction

    // Wall bit that faces the given direction.
    function automatic logic [WALL_W-1:0] wall_bit(logic [1:0] dir);
        logic [WALL_W-1:0] m;
        m = '0;
        m[dir] = 1'b1;
        return m;
    endfunction

    // Wall bit on the far side of the shared wall pair.
    function automatic logic [WALL_W-1:0] opposite_bit(logic [1:0] dir);
        logic [WALL_W-1:0] m;
        m = '0;
        unique case (dir)
            DIR_TOP:    m[DIR_BOTTOM] = 1'b1;
            DIR_BOTTOM: m[DIR_TOP]    = 1'b1;
            DIR_LEFT:   m[DIR_RIGHT]  = 1'b1;
            DIR_RIGHT:  m[DIR_LEFT]   = 1'b1;
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/gufwc_ram.sv =====
// ----------------------------------------------------------------------------
// gufwc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gufwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/gufwc_colmod.sv =====
// ----------------------------------------------------------------------------
// gufwc_colmod
// Column of a cell: remainder of the cell index by the grid width,
// found by restoring division one bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gufwc_colmod (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [gufwc_pkg::ADDR_W-1:0]      dividend,
    input  logic [gufwc_pkg::GW_W-1:0]        divisor,
    output logic                              done,
    output logic [gufwc_pkg::GW_W-1:0]        remainder
);

    localparam int STEP_W = $clog2(gufwc_pkg::ADDR_W);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [gufwc_pkg::ADDR_W-1:0]  dvd_reg, dvd_next;
    logic [gufwc_pkg::GW_W-1:0]    rem_reg, rem_next;
    logic [gufwc_pkg::GW_W-1:0]    dvs_reg, dvs_next;
    logic [gufwc_pkg::GW_W:0]      trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dvd_reg[gufwc_pkg::ADDR_W-1]};
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
            end
            rem_next  = trial[gufwc_pkg::GW_W-1:0];
            dvd_next  = {dvd_reg[gufwc_pkg::ADDR_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(gufwc_pkg::ADDR_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    `GUFWC_ASSERT(a_rem_below_divisor, clk, rst_n, done_reg |-> (rem_reg < dvs_reg), "column remainder not below grid width")
    `GUFWC_ASSERT(a_done_after_run, clk, rst_n, $rose(done_reg) |-> $past(run_reg), "column done without a running division")

endmodule

// ===== hw/rtl/grid_union_find_wall_carver_top.sv =====
// ----------------------------------------------------------------------------
// grid_union_find_wall_carver_top
// Maze carver over a grid of cells kept as a union-find forest with walls.
// ----------------------------------------------------------------------------
// Usage: each input transfer names a cell and a direction. The block finds
// the neighbour in that direction, and when both cells lie in different sets
// it joins the sets by size and clears the shared wall pair. Exactly one
// result transfer follows each input transfer, in order. Configuration
// (grid width, cell count) is to be written through the plain write port
// while the block is idle; the block does not enforce it. No read-back.
// Work per item, in order: the column computation; a find walk of the cell,
// one parent read per step, then its compression writes; the same for the
// neighbour; when the roots differ, the join (read and write of both roots)
// and the two wall updates; a final find of the cell, the wall read and the
// load of the output register. Every table access goes through the single
// shared table memory.
// One item is in work at a time: in_stall is high from acceptance until the
// result has been placed in the output register, and that register keeps
// the result while out_stall is high.
// Reset restores every table entry (parent = own index, size 1, all walls)
// at once through per-entry valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_union_find_wall_carver_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [gufwc_pkg::CNT_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  gufwc_pkg::req_t                 in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output gufwc_pkg::rsp_t                 out_data
);

    localparam int AW = gufwc_pkg::ADDR_W;

    // Configuration registers.
    logic [gufwc_pkg::GW_W-1:0]  grid_width_reg;
    logic [gufwc_pkg::CNT_W-1:0] cell_count_reg;

    // Sequencer state.
    gufwc_pkg::state_t state_reg, state_next;
    gufwc_pkg::call_t  call_reg, call_next;

    // Item context.
    logic [AW-1:0]                cell_reg, cell_next;
    logic [1:0]                   dir_reg, dir_next;
    logic [gufwc_pkg::GW_W-1:0]   w_reg, w_next;
    logic [gufwc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]                nb_reg, nb_next;
    logic                         nbv_reg, nbv_next;
    logic                         joined_reg, joined_next;
    logic [AW-1:0]                ra_reg, ra_next;
    logic [AW-1:0]                rb_reg, rb_next;
    logic [AW-1:0]                r_reg, r_next;
    logic [AW-1:0]                node_reg, node_next;
    logic [AW-1:0]                root_reg, root_next;
    gufwc_pkg::entry_t            word_a_reg, word_a_next;
    logic [gufwc_pkg::SIZE_W-1:0] sum_reg, sum_next;
    logic                         le_reg, le_next;
    gufwc_pkg::rsp_t              res_reg, res_next;

    // Output register.
    logic            out_valid_reg, out_valid_next;
    gufwc_pkg::rsp_t out_reg, out_next;

    // Table memory and its valid flags.
    logic [gufwc_pkg::CELLS-1:0] vld_reg, vld_next;
    logic [AW-1:0]               raddr, raddr_q;
    logic                        mem_we;
    logic [AW-1:0]               waddr;
    gufwc_pkg::entry_t           wdata;
    logic [gufwc_pkg::ENTRY_W-1:0] ram_q;
    gufwc_pkg::entry_t           rdata;

    // Column unit.
    logic                        div_start;
    logic                        div_done;
    logic [gufwc_pkg::GW_W-1:0]  div_rem;

    // Helpers.
    logic                         in_accept;
    logic                         out_free;
    logic [gufwc_pkg::GW_W-1:0]   w_eff;
    logic [gufwc_pkg::CNT_W-1:0]  cnt_eff;
    logic [gufwc_pkg::CNT_W-1:0]  cell9;
    logic [gufwc_pkg::CNT_W-1:0]  w9;
    logic                         nb_ok;
    logic [AW-1:0]                nb_calc;
    logic [gufwc_pkg::SIZE_W:0]   sum_wide;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // A zero width acts as one; counts beyond the table are clipped.
    assign w_eff   = (grid_width_reg == '0) ? gufwc_pkg::GW_W'(1) : grid_width_reg;
    assign cnt_eff = (cell_count_reg > gufwc_pkg::CNT_MAX) ? gufwc_pkg::CNT_MAX
                                                           : cell_count_reg;

    assign cell9 = {1'b0, cell_reg};
    assign w9    = {{(gufwc_pkg::CNT_W - gufwc_pkg::GW_W){1'b0}}, w_reg};

    // Neighbour and its grid check, once the column is known.
    always_comb
    begin
        nb_ok   = 1'b0;
        nb_calc = '0;
        unique case (dir_reg)
            gufwc_pkg::DIR_TOP:
            begin
                if (cell9 >= w9)
                begin
                    nb_ok   = 1'b1;
                    nb_calc = AW'(cell9 - w9);
                end
            end
            gufwc_pkg::DIR_BOTTOM:
            begin
                if ((cell9 + w9) < cnt_reg)
                begin
                    nb_ok   = 1'b1;
                    nb_calc = AW'(cell9 + w9);
                end
            end
            gufwc_pkg::DIR_LEFT:
            begin
                if (div_rem != '0)
                begin
                    nb_ok   = 1'b1;
                    nb_calc = cell_reg - AW'(1);
                end
            end
            gufwc_pkg::DIR_RIGHT:
            begin
                if ((div_rem != (w_reg - gufwc_pkg::GW_W'(1)))
                    && ((cell9 + gufwc_pkg::CNT_W'(1)) < cnt_reg))
                begin
                    nb_ok   = 1'b1;
                    nb_calc = cell_reg + AW'(1);
                end
            end
            default:
            begin
                nb_ok   = 1'b0;
                nb_calc = '0;
            end
        endcase
    end

    // Entries never written read as their reset value.
    assign rdata = vld_reg[raddr_q] ? gufwc_pkg::entry_t'(ram_q)
                                    : gufwc_pkg::reset_entry(raddr_q);

    assign sum_wide = {1'b0, word_a_reg.size} + {1'b0, rdata.size};

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gufwc_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    if ({1'b0, in_data.cell_req} >= cnt_eff)
                    begin
                        state_next = gufwc_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = gufwc_pkg::S_DIV;
                    end
                end
            end
            gufwc_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = gufwc_pkg::S_FR;
                end
            end
            gufwc_pkg::S_FR:  state_next = gufwc_pkg::S_FU;
            gufwc_pkg::S_FU:
            begin
                if (rdata.parent == r_reg)
                begin
                    state_next = gufwc_pkg::S_CR;
                end
                else
                begin
                    state_next = gufwc_pkg::S_FR;
                end
            end
            gufwc_pkg::S_CR:
            begin
                if (node_reg != r_reg)
                begin
                    state_next = gufwc_pkg::S_CU;
                end
                else
                begin
                    unique case (call_reg)
                        gufwc_pkg::CALL_CELL:  state_next = gufwc_pkg::S_FR;
                        gufwc_pkg::CALL_NB:
                        begin
                            if (ra_reg != r_reg)
                            begin
                                state_next = gufwc_pkg::S_UAR;
                            end
                            else
                            begin
                                state_next = gufwc_pkg::S_FR;
                            end
                        end
                        gufwc_pkg::CALL_FINAL: state_next = gufwc_pkg::S_WFR;
                        default:               state_next = gufwc_pkg::S_IDLE;
                    endcase
                end
            end
            gufwc_pkg::S_CU:  state_next = gufwc_pkg::S_CR;
            gufwc_pkg::S_UAR: state_next = gufwc_pkg::S_UAU;
            gufwc_pkg::S_UAU: state_next = gufwc_pkg::S_UBR;
            gufwc_pkg::S_UBR: state_next = gufwc_pkg::S_UBU;
            gufwc_pkg::S_UBU: state_next = gufwc_pkg::S_UAW;
            gufwc_pkg::S_UAW: state_next = gufwc_pkg::S_WCR;
            gufwc_pkg::S_WCR: state_next = gufwc_pkg::S_WCU;
            gufwc_pkg::S_WCU: state_next = gufwc_pkg::S_WNR;
            gufwc_pkg::S_WNR: state_next = gufwc_pkg::S_WNU;
            gufwc_pkg::S_WNU: state_next = gufwc_pkg::S_FR;
            gufwc_pkg::S_WFR: state_next = gufwc_pkg::S_WFU;
            gufwc_pkg::S_WFU: state_next = gufwc_pkg::S_DONE;
            gufwc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = gufwc_pkg::S_IDLE;
                end
            end
            default: state_next = gufwc_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        call_next      = call_reg;
        cell_next      = cell_reg;
        dir_next       = dir_reg;
        w_next         = w_reg;
        cnt_next       = cnt_reg;
        nb_next        = nb_reg;
        nbv_next       = nbv_reg;
        joined_next    = joined_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        r_next         = r_reg;
        node_next      = node_reg;
        root_next      = root_reg;
        word_a_next    = word_a_reg;
        sum_next       = sum_reg;
        le_next        = le_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        vld_next       = vld_reg;
        raddr          = raddr_q;
        mem_we         = 1'b0;
        waddr          = node_reg;
        wdata          = rdata;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            gufwc_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    cell_next   = in_data.cell_req;
                    dir_next    = in_data.direction;
                    w_next      = w_eff;
                    cnt_next    = cnt_eff;
                    joined_next = 1'b0;
                    res_next    = '0;
                    div_start   = ({1'b0, in_data.cell_req} < cnt_eff);
                end
            end
            gufwc_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    nbv_next  = nb_ok;
                    nb_next   = nb_calc;
                    r_next    = cell_reg;
                    node_next = cell_reg;
                    call_next = nb_ok ? gufwc_pkg::CALL_CELL : gufwc_pkg::CALL_FINAL;
                end
            end
            gufwc_pkg::S_FR:
            begin
                raddr = r_reg;
            end
            gufwc_pkg::S_FU:
            begin
                if (rdata.parent != r_reg)
                begin
                    r_next = rdata.parent;
                end
            end
            gufwc_pkg::S_CR:
            begin
                if (node_reg != r_reg)
                begin
                    raddr = node_reg;
                end
                else
                begin
                    unique case (call_reg)
                        gufwc_pkg::CALL_CELL:
                        begin
                            ra_next   = r_reg;
                            r_next    = nb_reg;
                            node_next = nb_reg;
                            call_next = gufwc_pkg::CALL_NB;
                        end
                        gufwc_pkg::CALL_NB:
                        begin
                            rb_next = r_reg;
                            if (ra_reg == r_reg)
                            begin
                                r_next    = cell_reg;
                                node_next = cell_reg;
                                call_next = gufwc_pkg::CALL_FINAL;
                            end
                        end
                        gufwc_pkg::CALL_FINAL:
                        begin
                            root_next = r_reg;
                        end
                        default:
                        begin
                            root_next = r_reg;
                        end
                    endcase
                end
            end
            gufwc_pkg::S_CU:
            begin
                // Point this node of the walk straight at the root.
                mem_we       = 1'b1;
                waddr        = node_reg;
                wdata        = rdata;
                wdata.parent = r_reg;
                node_next    = rdata.parent;
            end
            gufwc_pkg::S_UAR:
            begin
                raddr = ra_reg;
            end
            gufwc_pkg::S_UAU:
            begin
                word_a_next = rdata;
            end
            gufwc_pkg::S_UBR:
            begin
                raddr = rb_reg;
            end
            gufwc_pkg::S_UBU:
            begin
                sum_next = (sum_wide > {1'b0, gufwc_pkg::SIZE_CAP})
                         ? gufwc_pkg::SIZE_CAP : sum_wide[gufwc_pkg::SIZE_W-1:0];
                le_next  = (word_a_reg.size <= rdata.size);
                mem_we   = 1'b1;
                waddr    = rb_reg;
                wdata    = rdata;
                if (word_a_reg.size <= rdata.size)
                begin
                    wdata.size = (sum_wide > {1'b0, gufwc_pkg::SIZE_CAP})
                               ? gufwc_pkg::SIZE_CAP : sum_wide[gufwc_pkg::SIZE_W-1:0];
                end
                else
                begin
                    wdata.parent = ra_reg;
                end
            end
            gufwc_pkg::S_UAW:
            begin
                mem_we      = 1'b1;
                waddr       = ra_reg;
                wdata       = word_a_reg;
                joined_next = 1'b1;
                if (le_reg)
                begin
                    wdata.parent = rb_reg;
                end
                else
                begin
                    wdata.size = sum_reg;
                end
            end
            gufwc_pkg::S_WCR:
            begin
                raddr = cell_reg;
            end
            gufwc_pkg::S_WCU:
            begin
                mem_we      = 1'b1;
                waddr       = cell_reg;
                wdata       = rdata;
                wdata.walls = rdata.walls & ~gufwc_pkg::wall_bit(dir_reg);
            end
            gufwc_pkg::S_WNR:
            begin
                raddr = nb_reg;
            end
            gufwc_pkg::S_WNU:
            begin
                mem_we      = 1'b1;
                waddr       = nb_reg;
                wdata       = rdata;
                wdata.walls = rdata.walls & ~gufwc_pkg::opposite_bit(dir_reg);
                r_next      = cell_reg;
                node_next   = cell_reg;
                call_next   = gufwc_pkg::CALL_FINAL;
            end
            gufwc_pkg::S_WFR:
            begin
                raddr = cell_reg;
            end
            gufwc_pkg::S_WFU:
            begin
                res_next.neighbour_valid = nbv_reg;
                res_next.joined          = joined_reg;
                res_next.neighbour       = nb_reg;
                res_next.set_root        = root_reg;
                res_next.cell_walls      = rdata.walls;
            end
            gufwc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                end
            end
            default:
            begin
                raddr = raddr_q;
            end
        endcase

        if (mem_we)
        begin
            vld_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gufwc_pkg::S_IDLE;
            call_reg       <= gufwc_pkg::CALL_CELL;
            out_valid_reg  <= 1'b0;
            vld_reg        <= '0;
            grid_width_reg <= gufwc_pkg::GW_RESET;
            cell_count_reg <= gufwc_pkg::CNT_RESET;
            raddr_q        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            call_reg      <= call_next;
            out_valid_reg <= out_valid_next;
            vld_reg       <= vld_next;
            raddr_q       <= raddr;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    gufwc_pkg::REG_GRID_WIDTH:
                        grid_width_reg <= cfg_data[gufwc_pkg::GW_W-1:0];
                    gufwc_pkg::REG_CELL_COUNT:
                        cell_count_reg <= cfg_data;
                    default:
                        cell_count_reg <= cell_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg   <= cell_next;
        dir_reg    <= dir_next;
        w_reg      <= w_next;
        cnt_reg    <= cnt_next;
        nb_reg     <= nb_next;
        nbv_reg    <= nbv_next;
        joined_reg <= joined_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        r_reg      <= r_next;
        node_reg   <= node_next;
        root_reg   <= root_next;
        word_a_reg <= word_a_next;
        sum_reg    <= sum_next;
        le_reg     <= le_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    gufwc_ram #(
        .WIDTH (gufwc_pkg::ENTRY_W),
        .DEPTH (gufwc_pkg::CELLS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // The column unit loads its operands at the accepting edge, so it takes
    // the values that are being captured into the item context.
    gufwc_colmod u_colmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (cell_next),
        .divisor   (w_next),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign in_stall  = (state_reg != gufwc_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `GUFWC_ASSERT(a_out_from_done, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg == gufwc_pkg::S_DONE),
        "result appeared outside the completion step")
    `GUFWC_ASSERT(a_idle_no_write, clk, rst_n,
        (state_reg == gufwc_pkg::S_IDLE) |-> !mem_we,
        "table written while idle")
    `GUFWC_ASSERT(a_join_distinct, clk, rst_n,
        (state_reg == gufwc_pkg::S_UAW) |-> (ra_reg != rb_reg),
        "join of a set with itself")
    `GUFWC_ASSERT(a_div_in_div, clk, rst_n,
        div_done |-> (state_reg == gufwc_pkg::S_DIV),
        "column result outside the column step")

endmodule

// ===== bench/grid_union_find_wall_carver_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_union_find_wall_carver_top_test
// Self-checking bench for the union-find maze carver.
// ----------------------------------------------------------------------------
// Directed requests and random bursts are driven; the result side stalls on
// its own pattern. A scoreboard keeps its own copy of the parent, size and
// wall tables, predicts each result as a request transfer is accepted, and
// checks every result transfer in order. The grid shape is changed between
// phases while the block is idle, including the extreme register values.
// ----------------------------------------------------------------------------
module grid_union_find_wall_carver_top_test;

    // Scoreboard: a private union-find maze and the queue of pending results.
    class carve_scoreboard;
        logic [7:0]      parent [gufwc_pkg::CELLS];
        logic [8:0]      set_sz [gufwc_pkg::CELLS];
        logic [3:0]      walls [gufwc_pkg::CELLS];
        logic [4:0]      width_reg;
        logic [8:0]      count_reg;
        gufwc_pkg::rsp_t pending [$];
        int              errors;

        function void clear();
            for (int i = 0; i < gufwc_pkg::CELLS; i++)
            begin
                parent[i] = 8'(i);
                set_sz[i] = 9'd1;
                walls[i]  = 4'hF;
            end
            width_reg = gufwc_pkg::GW_RESET;
            count_reg = gufwc_pkg::CNT_RESET;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [8:0] val);
            if (idx == gufwc_pkg::REG_GRID_WIDTH)
                width_reg = val[4:0];
            else
                count_reg = val;
        endfunction

        // Find with full path compression.
        function int find_root(int node);
            int r;
            int nxt;
            r = node;
            while (parent[r] != r)
                r = parent[r];
            while (node != r)
            begin
                nxt = parent[node];
                parent[node] = 8'(r);
                node = nxt;
            end
            return r;
        endfunction

        task report_mismatch(string what, int exp, int got);
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp, got);
            errors++;
        endtask

        function void note_request(gufwc_pkg::req_t rq);
            gufwc_pkg::rsp_t rs;
            int w;
            int cnt;
            int c;
            int nb;
            int ra;
            int rb;
            int sum;
            w   = (width_reg == 0) ? 1 : width_reg;
            cnt = (count_reg > gufwc_pkg::CELLS) ? gufwc_pkg::CELLS : count_reg;
            c   = rq.cell_req;
            nb  = 0;
            rs  = '0;
            if (c < cnt)
            begin
                case (rq.direction)
                    gufwc_pkg::DIR_TOP:
                        if (c >= w)
                        begin
                            nb = c - w;
                            rs.neighbour_valid = 1;
                        end
                    gufwc_pkg::DIR_BOTTOM:
                        if (c + w < cnt)
                        begin
                            nb = c + w;
                            rs.neighbour_valid = 1;
                        end
                    gufwc_pkg::DIR_LEFT:
                        if (c % w != 0)
                        begin
                            nb = c - 1;
                            rs.neighbour_valid = 1;
                        end
                    default:
                        if ((c + 1) % w != 0 && c + 1 < cnt)
                        begin
                            nb = c + 1;
                            rs.neighbour_valid = 1;
                        end
                endcase
                if (rs.neighbour_valid)
                begin
                    ra = find_root(c);
                    rb = find_root(nb);
                    if (ra != rb)
                    begin
                        sum = set_sz[ra] + set_sz[rb];
                        if (sum > gufwc_pkg::SIZE_CAP)
                            sum = gufwc_pkg::SIZE_CAP;
                        if (set_sz[ra] <= set_sz[rb])
                        begin
                            set_sz[rb] = 9'(sum);
                            parent[ra] = 8'(rb);
                        end
                        else
                        begin
                            set_sz[ra] = 9'(sum);
                            parent[rb] = 8'(ra);
                        end
                        walls[c]  = walls[c] & ~gufwc_pkg::wall_bit(rq.direction);
                        walls[nb] = walls[nb] & ~gufwc_pkg::opposite_bit(rq.direction);
                        rs.joined = 1;
                    end
                end
                rs.neighbour  = 8'(nb);
                rs.set_root   = 8'(find_root(c));
                rs.cell_walls = walls[c];
            end
            pending.push_back(rs);
        endfunction

        task check_result(gufwc_pkg::rsp_t got);
            gufwc_pkg::rsp_t exp;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing expected", 0, 1);
                return;
            end
            exp = pending.pop_front();
            if (got.neighbour_valid !== exp.neighbour_valid)
                report_mismatch("neighbour_valid", exp.neighbour_valid, got.neighbour_valid);
            if (got.joined !== exp.joined)
                report_mismatch("joined", exp.joined, got.joined);
            if (got.neighbour !== exp.neighbour)
                report_mismatch("neighbour", exp.neighbour, got.neighbour);
            if (got.set_root !== exp.set_root)
                report_mismatch("set_root", exp.set_root, got.set_root);
            if (got.cell_walls !== exp.cell_walls)
                report_mismatch("cell_walls", exp.cell_walls, got.cell_walls);
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    logic            cfg_index;
    logic [8:0]      cfg_data;
    logic            in_valid;
    logic            in_stall;
    gufwc_pkg::req_t in_data;
    logic            out_valid;
    logic            out_stall;
    gufwc_pkg::rsp_t out_data;

    carve_scoreboard maze;
    // Receiver stall style: 0 never, 1 light, 2 heavy.
    int stall_mode;

    grid_union_find_wall_carver_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Requests and results are both observed at the rising edge, where the
    // handshake decides the transfer.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            maze.note_request(in_data);
        if (rst_n && out_valid && !out_stall)
            maze.check_result(out_data);
    end

    // Receiver stalls on a pattern of its own, changed at the falling edge.
    always @(negedge clk)
    begin
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Sends one carve request; returns once the transfer has happened.
    task automatic send_carve(logic [7:0] cell_idx, logic [1:0] dir);
        in_valid <= 1'b1;
        in_data  <= '{cell_req: cell_idx, direction: dir};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drop_valid(int gap);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
    endtask

    // Waits until every result is in, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (maze.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        maze.write_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random phase: mostly cells inside the grid, some beyond it.
    task automatic random_phase(int items, int cnt);
        int burst;
        int sent;
        logic [7:0] cell_idx;
        sent = 0;
        while (sent < items)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < items; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    cell_idx = 8'($urandom_range(0, 255));
                else
                    cell_idx = 8'($urandom_range(0, cnt - 1));
                send_carve(cell_idx, 2'($urandom_range(0, 3)));
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                drop_valid($urandom_range(1, 30));
        end
    endtask

    initial
    begin
        maze = new();
        maze.clear();
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = gufwc_pkg::REG_GRID_WIDTH;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        stall_mode = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset shape 16 x 16, corners and edges in every direction.
        send_carve(8'd0, gufwc_pkg::DIR_TOP);
        send_carve(8'd0, gufwc_pkg::DIR_LEFT);
        send_carve(8'd0, gufwc_pkg::DIR_RIGHT);
        send_carve(8'd0, gufwc_pkg::DIR_BOTTOM);
        send_carve(8'd1, gufwc_pkg::DIR_LEFT);
        send_carve(8'd15, gufwc_pkg::DIR_RIGHT);
        send_carve(8'd255, gufwc_pkg::DIR_BOTTOM);
        send_carve(8'd255, gufwc_pkg::DIR_RIGHT);
        send_carve(8'd255, gufwc_pkg::DIR_TOP);
        send_carve(8'd239, gufwc_pkg::DIR_BOTTOM);
        send_carve(8'd16, gufwc_pkg::DIR_TOP);
        drain();

        // Zero width acts as one column; cells beyond the count give zeros.
        write_reg(gufwc_pkg::REG_GRID_WIDTH, 9'd0);
        write_reg(gufwc_pkg::REG_CELL_COUNT, 9'd4);
        send_carve(8'd0, gufwc_pkg::DIR_BOTTOM);
        send_carve(8'd3, gufwc_pkg::DIR_TOP);
        send_carve(8'd2, gufwc_pkg::DIR_LEFT);
        send_carve(8'd4, gufwc_pkg::DIR_TOP);
        send_carve(8'd255, gufwc_pkg::DIR_RIGHT);
        drain();

        // Count above the table size is clipped; widest row width.
        write_reg(gufwc_pkg::REG_GRID_WIDTH, 9'd31);
        write_reg(gufwc_pkg::REG_CELL_COUNT, 9'd511);
        send_carve(8'd30, gufwc_pkg::DIR_RIGHT);
        send_carve(8'd200, gufwc_pkg::DIR_TOP);
        send_carve(8'd254, gufwc_pkg::DIR_RIGHT);
        drain();

        stall_mode = 1;
        write_reg(gufwc_pkg::REG_GRID_WIDTH, 9'd16);
        write_reg(gufwc_pkg::REG_CELL_COUNT, 9'd256);
        random_phase(200, 256);
        drain();

        stall_mode = 2;
        write_reg(gufwc_pkg::REG_GRID_WIDTH, 9'd2);
        write_reg(gufwc_pkg::REG_CELL_COUNT, 9'd4);
        random_phase(40, 4);
        drain();

        stall_mode = 0;
        write_reg(gufwc_pkg::REG_GRID_WIDTH, 9'd7);
        write_reg(gufwc_pkg::REG_CELL_COUNT, 9'd100);
        random_phase(130, 100);
        drain();

        stall_mode = 1;
        write_reg(gufwc_pkg::REG_GRID_WIDTH, 9'd5);
        write_reg(gufwc_pkg::REG_CELL_COUNT, 9'd256);
        random_phase(130, 256);
        drain();

        if (maze.errors == 0)
            $display("grid_union_find_wall_carver_top regression: pass");
        else
            $display("grid_union_find_wall_carver_top regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("grid_union_find_wall_carver_top regression: fail");
        $finish;
    end

endmodule
